[rtl/core/soa_pkg.sv]
package soa_pkg;

  // Geometry of the cache.
  localparam int NUM_SLABS   = 16;
  localparam int SLAB_AW     = 4;
  localparam int MAX_OBJECTS = 256;
  localparam int OBJ_AW      = 8;
  localparam int SLOT_AW     = SLAB_AW + OBJ_AW;
  localparam int WIN_BITS    = 16;
  localparam int ADDR_W      = 20;
  localparam int SIZE_W      = 15;
  localparam int CNT_W       = 9;
  localparam int DIV_W       = WIN_BITS + 1;

  localparam logic [SLAB_AW:0] NIL_SLAB = (SLAB_AW + 1)'(NUM_SLABS);
  localparam logic [OBJ_AW:0]  NIL_SLOT = (OBJ_AW + 1)'(MAX_OBJECTS);

  // List kinds.
  localparam logic [1:0] KIND_EMPTY   = 2'd0;
  localparam logic [1:0] KIND_PARTIAL = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;

  // Commands.
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_SHRINK = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_SLAB  = 2'd1;
  localparam logic [1:0] STAT_BAD_ADDR = 2'd2;
  localparam logic [1:0] STAT_NOT_USED = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_OBJ_BYTES = 1'b0;
  localparam logic CFG_OBJS      = 1'b1;

  // One entry of the slab descriptor memory. The cap field holds the
  // watermark the slab started with in its current life.
  typedef struct packed {
    logic              live;
    logic [1:0]        kind;
    logic [SLAB_AW:0]  next;
    logic [SLAB_AW:0]  prev;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  wm;
    logic [CNT_W-1:0]  cap;
    logic [OBJ_AW:0]   stk;
  } soa_rec_t;

  // One entry of the slot memory: busy flag and free stack link.
  typedef struct packed {
    logic              busy;
    logic [OBJ_AW:0]   link;
  } soa_slot_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_REC_RD,
    ST_DIV,
    ST_POP,
    ST_SLOT_RD,
    ST_UPD,
    ST_FREE_CHK,
    ST_MV_P,
    ST_MV_PW,
    ST_MV_N,
    ST_MV_NW,
    ST_MV_H,
    ST_MV_HW,
    ST_REC_WR,
    ST_SHR,
    ST_DONE
  } soa_state_e;

endpackage

[rtl/core/slab_object_allocator.sv]
// Slab object allocator for one cache of 16 slabs of 64 KiB each. A request is
// taken when start is high and busy is low; exactly one result follows, shown
// for one cycle with done_o high, and the receiver cannot hold it off. Slab
// descriptors live in a 16-entry memory and slot state in a 4096-entry memory,
// both with registered read data, so each list step is a read and then a write.
// A free decodes the object index with the 17-step bit-serial divider, which
// also gives the object count when an allocate brings up a new slab; a shrink
// takes the empty slabs down one at a time.
// No clearing pass is needed after reset.
module slab_object_allocator import soa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command_i,
  input  logic [ADDR_W-1:0]  free_addr_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [SIZE_W-1:0]  cfg_wdata_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [ADDR_W-1:0]  obj_addr_o,
  output logic [SLAB_AW-1:0] slab_index_o,
  output logic [4:0]         freed_slabs_o,
  output logic [12:0]        active_objects_o,
  output logic [4:0]         slab_count_o,
  output logic [4:0]         empty_slabs_o,
  output logic [31:0]        alloc_total_o,
  output logic [31:0]        free_total_o
);

  soa_state_e state_q, state_d;

  logic [SIZE_W-1:0]  obj_bytes_q;
  logic [CNT_W-1:0]   objs_q;
  logic [SLAB_AW:0]   heads_q [3];
  logic [NUM_SLABS-1:0] live_q;
  logic [12:0]        active_q;
  logic [4:0]         total_q;
  logic [4:0]         empty_q;
  logic [31:0]        alloc_q;
  logic [31:0]        free_q;

  logic [1:0]         cmd_q;
  logic [WIN_BITS-1:0] off_q;
  logic [SLAB_AW-1:0] s_q;
  logic               create_q;
  soa_rec_t           rec_q;
  logic [OBJ_AW-1:0]  idx_q;
  logic [1:0]         mv_to_q;
  logic               mv_unlink_q;
  logic [SLAB_AW:0]   hd_q;
  logic [1:0]         status_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [SLAB_AW-1:0] slab_out_q;
  logic [4:0]         freed_q;

  // Memories.
  soa_rec_t           smem [NUM_SLABS];
  soa_rec_t           smem_rdata;
  logic [SLAB_AW-1:0] smem_raddr;
  logic               smem_we;
  logic [SLAB_AW-1:0] smem_waddr;
  soa_rec_t           smem_wdata;

  soa_slot_t          tmem [NUM_SLABS * MAX_OBJECTS];
  soa_slot_t          tmem_rdata;
  logic [SLOT_AW-1:0] tmem_raddr;
  logic               tmem_we;
  logic [SLOT_AW-1:0] tmem_waddr;
  soa_slot_t          tmem_wdata;

  // Divider.
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic [SIZE_W-1:0]  div_rem;

  // Derived values.
  logic [SIZE_W-1:0]  sz_w;
  logic [CNT_W-1:0]   nc_w;
  logic [SLAB_AW-1:0] low_free_w;
  logic [SLAB_AW-1:0] alloc_s_w;
  logic               create_w;
  logic               noslab_w;
  logic               has_slot_w;
  logic [1:0]         tgt_w;
  logic               bad_addr_w;
  logic               slot_busy_w;
  logic [CNT_W-1:0]   used_dec_w;
  logic [CNT_W-1:0]   wm_fresh_w;
  logic [OBJ_AW+SIZE_W-1:0] prod_w;

  // Effective size and object count from the registers.
  always_comb begin
    sz_w = (obj_bytes_q[SIZE_W-1:3] == '0) ? SIZE_W'(8) : {obj_bytes_q[SIZE_W-1:3], 3'b000};
    if (objs_q == '0) begin
      nc_w = CNT_W'(1);
    end else if (objs_q > CNT_W'(MAX_OBJECTS)) begin
      nc_w = CNT_W'(MAX_OBJECTS);
    end else begin
      nc_w = objs_q;
    end
  end

  // Lowest slab not yet created.
  always_comb begin
    low_free_w = '0;
    for (int i = NUM_SLABS - 1; i >= 0; i--) begin
      if (!live_q[i]) low_free_w = SLAB_AW'(i);
    end
  end

  // Allocation source: partial head, else empty head, else a new slab.
  always_comb begin
    create_w = 1'b0;
    if (heads_q[KIND_PARTIAL] != NIL_SLAB) begin
      alloc_s_w = heads_q[KIND_PARTIAL][SLAB_AW-1:0];
    end else if (heads_q[KIND_EMPTY] != NIL_SLAB) begin
      alloc_s_w = heads_q[KIND_EMPTY][SLAB_AW-1:0];
    end else begin
      alloc_s_w = low_free_w;
      create_w  = 1'b1;
    end
    noslab_w = create_w && (&live_q);
  end

  always_comb begin
    has_slot_w  = (rec_q.stk != NIL_SLOT) || (rec_q.wm != '0);
    tgt_w       = has_slot_w ? KIND_PARTIAL : KIND_FULL;
    bad_addr_w  = (div_rem != '0) || (div_quot >= DIV_W'(nc_w)) ||
                  (({1'b0, off_q} + DIV_W'(sz_w)) > DIV_W'(1 << WIN_BITS));
    // Only slots between the watermark and the starting watermark were handed
    // out in this slab's life; their busy flags were all written since then.
    slot_busy_w = tmem_rdata.busy && ({1'b0, idx_q} >= rec_q.wm) &&
                  ({1'b0, idx_q} < rec_q.cap);
    used_dec_w  = (rec_q.used != '0) ? rec_q.used - 1'b1 : rec_q.used;
    wm_fresh_w  = (div_quot < DIV_W'(nc_w)) ? div_quot[CNT_W-1:0] : nc_w;
    prod_w      = (OBJ_AW + SIZE_W)'(idx_q) * (OBJ_AW + SIZE_W)'(sz_w);
  end

  // Divider control: a new slab needs the window size over the object size,
  // a free needs the offset over the object size.
  always_comb begin
    div_start    = ((state_q == ST_IDLE) && start && (command_i == CMD_ALLOC) &&
                    create_w && !noslab_w) ||
                   ((state_q == ST_REC_RD) && (cmd_q == CMD_FREE));
    div_dividend = (state_q == ST_IDLE) ? DIV_W'(1 << WIN_BITS) : {1'b0, off_q};
  end

  soa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (sz_w),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (command_i)
            CMD_ALLOC:  state_d = noslab_w ? ST_DONE : (create_w ? ST_DIV : ST_REC_RD);
            CMD_FREE:   state_d = live_q[free_addr_i[ADDR_W-1:WIN_BITS]] ? ST_REC_RD : ST_DONE;
            CMD_SHRINK: state_d = (heads_q[KIND_EMPTY] != NIL_SLAB) ? ST_SHR : ST_DONE;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_REC_RD:   state_d = (cmd_q == CMD_ALLOC) ? ST_POP : ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (cmd_q == CMD_ALLOC) begin
            state_d = ST_POP;
          end else begin
            state_d = bad_addr_w ? ST_DONE : ST_FREE_CHK;
          end
        end
      end
      ST_POP:      state_d = (rec_q.stk != NIL_SLOT) ? ST_SLOT_RD : ST_UPD;
      ST_SLOT_RD:  state_d = ST_UPD;
      ST_UPD:      state_d = (create_q || (rec_q.kind != tgt_w)) ? ST_MV_P : ST_REC_WR;
      ST_FREE_CHK: begin
        if (!slot_busy_w) begin
          state_d = ST_DONE;
        end else if (used_dec_w == '0 || rec_q.kind == KIND_FULL) begin
          state_d = ST_MV_P;
        end else begin
          state_d = ST_REC_WR;
        end
      end
      ST_MV_P:  state_d = (mv_unlink_q && rec_q.prev != NIL_SLAB) ? ST_MV_PW : ST_MV_N;
      ST_MV_PW: state_d = ST_MV_N;
      ST_MV_N:  state_d = (mv_unlink_q && rec_q.next != NIL_SLAB) ? ST_MV_NW : ST_MV_H;
      ST_MV_NW: state_d = ST_MV_H;
      ST_MV_H:  state_d = (heads_q[mv_to_q] != NIL_SLAB) ? ST_MV_HW : ST_REC_WR;
      ST_MV_HW: state_d = ST_REC_WR;
      ST_REC_WR: state_d = ST_DONE;
      ST_SHR:   state_d = (smem_rdata.next != NIL_SLAB) ? ST_SHR : ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Memory addresses and write data.
  always_comb begin
    soa_rec_t nb;
    nb         = smem_rdata;
    smem_raddr = s_q;
    smem_we    = 1'b0;
    smem_waddr = s_q;
    smem_wdata = rec_q;
    tmem_raddr = {s_q, idx_q};
    tmem_we    = 1'b0;
    tmem_waddr = {s_q, idx_q};
    tmem_wdata = '{busy: 1'b1, link: '0};
    unique case (state_q)
      ST_IDLE: begin
        case (command_i)
          CMD_ALLOC:  smem_raddr = alloc_s_w;
          CMD_FREE:   smem_raddr = free_addr_i[ADDR_W-1:WIN_BITS];
          default:    smem_raddr = heads_q[KIND_EMPTY][SLAB_AW-1:0];
        endcase
      end
      ST_DIV:      tmem_raddr = {s_q, div_quot[OBJ_AW-1:0]};
      ST_POP:      tmem_raddr = {s_q, rec_q.stk[OBJ_AW-1:0]};
      ST_UPD:      tmem_we = 1'b1;
      ST_FREE_CHK: begin
        tmem_we    = slot_busy_w;
        tmem_wdata = '{busy: 1'b0, link: rec_q.stk};
      end
      ST_MV_P:     smem_raddr = rec_q.prev[SLAB_AW-1:0];
      ST_MV_PW: begin
        nb.next    = rec_q.next;
        smem_we    = 1'b1;
        smem_waddr = rec_q.prev[SLAB_AW-1:0];
        smem_wdata = nb;
      end
      ST_MV_N:     smem_raddr = rec_q.next[SLAB_AW-1:0];
      ST_MV_NW: begin
        nb.prev    = rec_q.prev;
        smem_we    = 1'b1;
        smem_waddr = rec_q.next[SLAB_AW-1:0];
        smem_wdata = nb;
      end
      ST_MV_H:     smem_raddr = heads_q[mv_to_q][SLAB_AW-1:0];
      ST_MV_HW: begin
        nb.prev    = {1'b0, s_q};
        smem_we    = 1'b1;
        smem_waddr = hd_q[SLAB_AW-1:0];
        smem_wdata = nb;
      end
      ST_REC_WR:   smem_we = 1'b1;
      ST_SHR: begin
        nb.live    = 1'b0;
        nb.kind    = KIND_EMPTY;
        nb.next    = NIL_SLAB;
        nb.prev    = NIL_SLAB;
        smem_we    = 1'b1;
        smem_wdata = nb;
        smem_raddr = smem_rdata.next[SLAB_AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Synchronous memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (smem_we) smem[smem_waddr] <= smem_wdata;
    smem_rdata <= smem[smem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tmem_we) tmem[tmem_waddr] <= tmem_wdata;
    tmem_rdata <= tmem[tmem_raddr];
  end

  // Control state, list heads and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      obj_bytes_q <= SIZE_W'(64);
      objs_q      <= CNT_W'(MAX_OBJECTS);
      heads_q     <= '{default: NIL_SLAB};
      live_q      <= '0;
      active_q    <= '0;
      total_q     <= '0;
      empty_q     <= '0;
      alloc_q     <= '0;
      free_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OBJ_BYTES: obj_bytes_q <= cfg_wdata_i;
          default:       objs_q      <= cfg_wdata_i[CNT_W-1:0];
        endcase
      end
      case (state_q)
        ST_UPD: begin
          active_q <= active_q + 1'b1;
          alloc_q  <= alloc_q + 1'b1;
          if (create_q) begin
            live_q[s_q] <= 1'b1;
            total_q     <= total_q + 1'b1;
          end else if (rec_q.used == '0) begin
            empty_q <= empty_q - 1'b1;
          end
        end
        ST_FREE_CHK: begin
          if (slot_busy_w) begin
            free_q <= free_q + 1'b1;
            if (rec_q.used != '0) active_q <= active_q - 1'b1;
            if (rec_q.used == CNT_W'(1)) empty_q <= empty_q + 1'b1;
          end
        end
        ST_MV_P: begin
          if (mv_unlink_q && rec_q.prev == NIL_SLAB) heads_q[rec_q.kind] <= rec_q.next;
        end
        ST_MV_H:  heads_q[mv_to_q] <= {1'b0, s_q};
        ST_SHR: begin
          live_q[s_q]         <= 1'b0;
          total_q             <= total_q - 1'b1;
          empty_q             <= empty_q - 1'b1;
          heads_q[KIND_EMPTY] <= smem_rdata.next;
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers and result fields.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cmd_q      <= command_i;
        off_q      <= free_addr_i[WIN_BITS-1:0];
        status_q   <= STAT_OK;
        addr_q     <= '0;
        slab_out_q <= '0;
        freed_q    <= '0;
        create_q   <= create_w;
        case (command_i)
          CMD_ALLOC: begin
            s_q <= alloc_s_w;
            if (noslab_w) status_q <= STAT_NO_SLAB;
          end
          CMD_FREE: begin
            s_q <= free_addr_i[ADDR_W-1:WIN_BITS];
            if (!live_q[free_addr_i[ADDR_W-1:WIN_BITS]]) status_q <= STAT_BAD_ADDR;
          end
          default: s_q <= heads_q[KIND_EMPTY][SLAB_AW-1:0];
        endcase
      end
      ST_REC_RD: rec_q <= smem_rdata;
      ST_DIV: begin
        if (div_done) begin
          if (cmd_q == CMD_ALLOC) begin
            rec_q <= '{live: 1'b1, kind: KIND_EMPTY, next: NIL_SLAB, prev: NIL_SLAB,
                       used: '0, wm: wm_fresh_w, cap: wm_fresh_w, stk: NIL_SLOT};
          end else if (bad_addr_w) begin
            status_q <= STAT_BAD_ADDR;
          end else begin
            idx_q <= div_quot[OBJ_AW-1:0];
          end
        end
      end
      ST_POP: begin
        if (rec_q.stk != NIL_SLOT) begin
          idx_q <= rec_q.stk[OBJ_AW-1:0];
        end else begin
          rec_q.wm <= rec_q.wm - 1'b1;
          idx_q    <= OBJ_AW'(rec_q.wm - 1'b1);
        end
      end
      ST_SLOT_RD: rec_q.stk <= tmem_rdata.link;
      ST_UPD: begin
        rec_q.used  <= rec_q.used + 1'b1;
        addr_q      <= {s_q, {WIN_BITS{1'b0}}} + prod_w[ADDR_W-1:0];
        slab_out_q  <= s_q;
        mv_to_q     <= tgt_w;
        mv_unlink_q <= !create_q;
      end
      ST_FREE_CHK: begin
        if (!slot_busy_w) begin
          status_q <= STAT_NOT_USED;
        end else begin
          rec_q.stk   <= {1'b0, idx_q};
          rec_q.used  <= used_dec_w;
          slab_out_q  <= s_q;
          mv_to_q     <= (used_dec_w == '0) ? KIND_EMPTY : KIND_PARTIAL;
          mv_unlink_q <= 1'b1;
        end
      end
      ST_MV_H: begin
        hd_q       <= heads_q[mv_to_q];
        rec_q.next <= heads_q[mv_to_q];
        rec_q.prev <= NIL_SLAB;
        rec_q.kind <= mv_to_q;
      end
      ST_SHR: begin
        freed_q <= freed_q + 1'b1;
        s_q     <= smem_rdata.next[SLAB_AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Outputs.
  assign busy             = (state_q != ST_IDLE);
  assign done_o           = (state_q == ST_DONE);
  assign status_o         = status_q;
  assign obj_addr_o       = addr_q;
  assign slab_index_o     = slab_out_q;
  assign freed_slabs_o    = freed_q;
  assign active_objects_o = active_q;
  assign slab_count_o     = total_q;
  assign empty_slabs_o    = empty_q;
  assign alloc_total_o    = alloc_q;
  assign free_total_o     = free_q;

endmodule

[rtl/core/soa_div.sv]
module soa_div import soa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quot_o,
  output logic [SIZE_W-1:0] rem_o
);

  logic                     busy_q;
  logic                     done_q;
  logic [$clog2(DIV_W)-1:0] cnt_q;
  logic [DIV_W-1:0]         quo_q;
  logic [SIZE_W-1:0]        rem_q;
  logic [SIZE_W:0]          trial;
  logic [SIZE_W:0]          diff;
  logic                     ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = trial >= {1'b0, divisor_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ($clog2(DIV_W))'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import soa_pkg::*;

  // Command code that the block ignores.
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int NIL_S = NUM_SLABS;
  localparam int NIL_O = MAX_OBJECTS;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  // Kinds of generated requests; free addresses are resolved at drive time.
  typedef enum int {
    GEN_ALLOC,
    GEN_FREE_LIVE,
    GEN_FREE_BAD,
    GEN_FREE_AGAIN,
    GEN_FREE_FIXED,
    GEN_SHRINK,
    GEN_ODD
  } gen_kind_e;

  typedef struct {
    gen_kind_e   kind;
    logic [19:0] addr;
  } gen_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [19:0] obj_addr;
    logic [3:0]  slab;
    logic [4:0]  freed;
    logic [12:0] active;
    logic [4:0]  total;
    logic [4:0]  empty;
    logic [31:0] allocs;
    logic [31:0] frees;
  } alloc_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         command_i;
  logic [ADDR_W-1:0]  free_addr_i;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [SIZE_W-1:0]  cfg_wdata_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic [ADDR_W-1:0]  obj_addr_o;
  logic [SLAB_AW-1:0] slab_index_o;
  logic [4:0]         freed_slabs_o;
  logic [12:0]        active_objects_o;
  logic [4:0]         slab_count_o;
  logic [4:0]         empty_slabs_o;
  logic [31:0]        alloc_total_o;
  logic [31:0]        free_total_o;

  slab_object_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .free_addr_i      (free_addr_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .obj_addr_o       (obj_addr_o),
    .slab_index_o     (slab_index_o),
    .freed_slabs_o    (freed_slabs_o),
    .active_objects_o (active_objects_o),
    .slab_count_o     (slab_count_o),
    .empty_slabs_o    (empty_slabs_o),
    .alloc_total_o    (alloc_total_o),
    .free_total_o     (free_total_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Shadow copy of the cache state and registers.
  logic [14:0] m_size_reg;
  logic [8:0]  m_count_reg;
  bit          m_live [NUM_SLABS];
  int          m_kind [NUM_SLABS];
  int          m_next [NUM_SLABS];
  int          m_prev [NUM_SLABS];
  int          m_heads [3];
  int          m_used [NUM_SLABS];
  int          m_wm [NUM_SLABS];
  int          m_stack [NUM_SLABS];
  int          m_chain [NUM_SLABS*MAX_OBJECTS];
  bit          m_busy [NUM_SLABS*MAX_OBJECTS];
  logic [31:0] m_allocs;
  logic [31:0] m_frees;

  // Addresses handed out and not yet freed, and addresses freed recently.
  logic [19:0] live_addrs [$];
  logic [19:0] freed_addrs [$];

  gen_req_t      pending_reqs [$];
  alloc_result_t expected_results [$];
  int            errors;
  int            quiet_cycles;
  bit            no_idle;
  int            gap;

  function automatic int eff_obj_bytes();
    int s;
    s = int'(m_size_reg) & ~7;
    return (s == 0) ? 8 : s;
  endfunction

  function automatic int obj_count();
    int n;
    int lim;
    n = int'(m_count_reg);
    lim = 65536 / eff_obj_bytes();
    if (n > MAX_OBJECTS) n = MAX_OBJECTS;
    if (n > lim) n = lim;
    if (n == 0) n = 1;
    return n;
  endfunction

  task automatic list_insert(input int k, input int s);
    int h;
    h = m_heads[k];
    m_next[s] = h;
    m_prev[s] = NIL_S;
    if (h < NIL_S) m_prev[h] = s;
    m_heads[k] = s;
    m_kind[s] = k;
  endtask

  task automatic list_remove(input int s);
    int p;
    int n;
    p = m_prev[s];
    n = m_next[s];
    if (p < NIL_S) m_next[p] = n;
    else m_heads[m_kind[s]] = n;
    if (n < NIL_S) m_prev[n] = p;
    m_next[s] = NIL_S;
    m_prev[s] = NIL_S;
  endtask

  task automatic model_reset();
    m_size_reg = 15'd64;
    m_count_reg = 9'd256;
    for (int i = 0; i < NUM_SLABS; i++) begin
      m_live[i] = 0;
      m_kind[i] = 0;
      m_next[i] = NIL_S;
      m_prev[i] = NIL_S;
      m_used[i] = 0;
      m_wm[i] = 0;
      m_stack[i] = NIL_O;
    end
    for (int i = 0; i < 3; i++) m_heads[i] = NIL_S;
    for (int i = 0; i < NUM_SLABS*MAX_OBJECTS; i++) begin
      m_chain[i] = 0;
      m_busy[i] = 0;
    end
    m_allocs = '0;
    m_frees = '0;
  endtask

  // Computes the result of one accepted request and updates the shadow state.
  task automatic serve_request(input logic [1:0] cmd, input logic [19:0] a,
                               output alloc_result_t r);
    int s;
    int idx;
    int off;
    int pos;
    int n;
    r = '{default: '0};
    if (cmd == CMD_ALLOC) begin
      s = m_heads[KIND_PARTIAL];
      if (s >= NIL_S) s = m_heads[KIND_EMPTY];
      if (s >= NIL_S) begin
        s = NIL_S;
        for (int i = NUM_SLABS - 1; i >= 0; i--) if (!m_live[i]) s = i;
        if (s < NIL_S) begin
          m_live[s] = 1;
          m_used[s] = 0;
          m_wm[s] = obj_count();
          m_stack[s] = NIL_O;
          list_insert(KIND_EMPTY, s);
        end
      end
      if (s >= NIL_S) begin
        r.status = STAT_NO_SLAB;
      end else begin
        if (m_stack[s] < NIL_O) begin
          idx = m_stack[s];
          m_stack[s] = m_chain[s*MAX_OBJECTS + idx];
        end else begin
          m_wm[s]--;
          idx = m_wm[s];
        end
        m_busy[s*MAX_OBJECTS + idx] = 1;
        m_used[s]++;
        list_remove(s);
        list_insert((m_stack[s] < NIL_O || m_wm[s] != 0) ? KIND_PARTIAL : KIND_FULL, s);
        m_allocs++;
        r.obj_addr = 20'(s*65536 + idx*eff_obj_bytes());
        r.slab = 4'(s);
        live_addrs.push_back(r.obj_addr);
      end
    end else if (cmd == CMD_FREE) begin
      s = int'(a[19:16]);
      off = int'(a[15:0]);
      if (!m_live[s] || (off % eff_obj_bytes()) != 0 ||
          (off / eff_obj_bytes()) >= obj_count()) begin
        r.status = STAT_BAD_ADDR;
      end else begin
        idx = off / eff_obj_bytes();
        pos = s*MAX_OBJECTS + idx;
        if (!m_busy[pos]) begin
          r.status = STAT_NOT_USED;
        end else begin
          m_busy[pos] = 0;
          m_chain[pos] = m_stack[s];
          m_stack[s] = idx;
          if (m_used[s] != 0) m_used[s]--;
          if (m_used[s] == 0) begin
            list_remove(s);
            list_insert(KIND_EMPTY, s);
          end else if (m_kind[s] == KIND_FULL) begin
            list_remove(s);
            list_insert(KIND_PARTIAL, s);
          end
          m_frees++;
          r.slab = 4'(s);
          foreach (live_addrs[i]) begin
            if (live_addrs[i] == a) begin
              live_addrs.delete(i);
              break;
            end
          end
          freed_addrs.push_back(a);
          if (freed_addrs.size() > 32) void'(freed_addrs.pop_front());
        end
      end
    end else if (cmd == CMD_SHRINK) begin
      n = 0;
      for (int g = 0; g < NUM_SLABS; g++) begin
        s = m_heads[KIND_EMPTY];
        if (s >= NIL_S) break;
        list_remove(s);
        m_live[s] = 0;
        m_kind[s] = 0;
        n++;
      end
      r.freed = 5'(n);
    end
    for (int i = 0; i < NUM_SLABS; i++) begin
      if (m_live[i]) begin
        r.total++;
        r.active += 13'(m_used[i]);
        if (m_used[i] == 0) r.empty++;
      end
    end
    r.allocs = m_allocs;
    r.frees = m_frees;
  endtask

  // Request driver: predicts on acceptance, then waits out a drawn gap.
  always @(posedge clk_i or negedge rst_ni) begin
    gen_req_t      req;
    alloc_result_t res;
    logic [19:0]   a;
    if (!rst_ni) begin
      start <= 1'b0;
      command_i <= CMD_ALLOC;
      free_addr_i <= '0;
      gap <= 0;
    end else begin
      if (start && !busy) begin
        serve_request(command_i, free_addr_i, res);
        expected_results.push_back(res);
      end
      if (!start || !busy) begin
        if (gap > 0) begin
          gap <= gap - 1;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req = pending_reqs.pop_front();
          a = 20'($urandom);
          case (req.kind)
            GEN_ALLOC: command_i <= CMD_ALLOC;
            GEN_SHRINK: command_i <= CMD_SHRINK;
            GEN_ODD: command_i <= CMD_NONE;
            GEN_FREE_FIXED: begin
              command_i <= CMD_FREE;
              a = req.addr;
            end
            GEN_FREE_LIVE: begin
              command_i <= CMD_FREE;
              if (live_addrs.size() > 0)
                a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
            end
            GEN_FREE_AGAIN: begin
              command_i <= CMD_FREE;
              if (freed_addrs.size() > 0)
                a = freed_addrs[$urandom_range(0, freed_addrs.size() - 1)];
            end
            default: begin
              command_i <= CMD_FREE;
              // Misaligned neighbor of a live object, or a random address.
              if (live_addrs.size() > 0 && $urandom_range(0, 1) == 1)
                a = live_addrs[$urandom_range(0, live_addrs.size() - 1)]
                    + 20'($urandom_range(1, 7));
            end
          endcase
          free_addr_i <= a;
          start <= 1'b1;
          gap <= no_idle ? 0 : $urandom_range(0, 16);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each strobed result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    alloc_result_t e;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          errors++;
        end
        if (obj_addr_o !== e.obj_addr) begin
          $error("obj_addr expected %0h actual %0h", e.obj_addr, obj_addr_o);
          errors++;
        end
        if (slab_index_o !== e.slab) begin
          $error("slab_index expected %0d actual %0d", e.slab, slab_index_o);
          errors++;
        end
        if (freed_slabs_o !== e.freed) begin
          $error("freed_slabs expected %0d actual %0d", e.freed, freed_slabs_o);
          errors++;
        end
        if (active_objects_o !== e.active) begin
          $error("active_objects expected %0d actual %0d", e.active, active_objects_o);
          errors++;
        end
        if (slab_count_o !== e.total) begin
          $error("slab_count expected %0d actual %0d", e.total, slab_count_o);
          errors++;
        end
        if (empty_slabs_o !== e.empty) begin
          $error("empty_slabs expected %0d actual %0d", e.empty, empty_slabs_o);
          errors++;
        end
        if (alloc_total_o !== e.allocs) begin
          $error("alloc_total expected %0d actual %0d", e.allocs, alloc_total_o);
          errors++;
        end
        if (free_total_o !== e.frees) begin
          $error("free_total expected %0d actual %0d", e.frees, free_total_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no acceptance, no result and no config write.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_req(input gen_kind_e k, input logic [19:0] a = '0);
    gen_req_t r;
    r.kind = k;
    r.addr = a;
    pending_reqs.push_back(r);
  endtask

  // Waits until every request has been sent and answered, then a little longer.
  task automatic drain();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || start || gap != 0 || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Writes both registers while the block is idle; the shadow copy follows.
  task automatic write_config(input logic [14:0] size_val, input logic [14:0] count_val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_OBJ_BYTES;
    cfg_wdata_i <= size_val;
    @(posedge clk_i);
    cfg_idx_i <= CFG_OBJS;
    cfg_wdata_i <= count_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_size_reg = size_val;
    m_count_reg = count_val[8:0];
  endtask

  // Random phase: well-formed alloc and free traffic with some noise.
  task automatic random_phase(input int items);
    int p_alloc;
    int roll;
    p_alloc = $urandom_range(35, 75);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < p_alloc) add_req(GEN_ALLOC);
      else if (roll < 88) add_req(GEN_FREE_LIVE);
      else if (roll < 92) add_req(GEN_FREE_BAD);
      else if (roll < 95) add_req(GEN_FREE_AGAIN);
      else if (roll < 99) add_req(GEN_SHRINK);
      else add_req(GEN_ODD);
    end
    drain();
  endtask

  initial begin
    logic [14:0] sz;
    logic [14:0] cnt;
    errors = 0;
    no_idle = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_OBJ_BYTES;
    cfg_wdata_i = '0;
    model_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed checks at the reset configuration.
    add_req(GEN_ALLOC);
    add_req(GEN_ALLOC);
    add_req(GEN_FREE_LIVE);
    add_req(GEN_FREE_AGAIN);
    add_req(GEN_FREE_FIXED, 20'h0FFC1);
    add_req(GEN_FREE_FIXED, 20'hF0000);
    add_req(GEN_FREE_FIXED, 20'h00000);
    add_req(GEN_FREE_FIXED, 20'hFFFFF);
    add_req(GEN_ODD);
    add_req(GEN_SHRINK);
    add_req(GEN_FREE_LIVE);
    add_req(GEN_SHRINK);
    add_req(GEN_ALLOC);
    add_req(GEN_SHRINK);
    drain();

    // Largest objects, four to a slab: run the cache out of slabs.
    write_config(15'd16384, 15'd4);
    for (int i = 0; i < 66; i++) add_req(GEN_ALLOC);
    add_req(GEN_FREE_LIVE);
    add_req(GEN_FREE_LIVE);
    add_req(GEN_ALLOC);
    add_req(GEN_SHRINK);
    drain();

    // Size zero acts as eight and a count of zero gives one-object slabs.
    write_config(15'd0, 15'h7E00);
    add_req(GEN_ALLOC);
    add_req(GEN_ALLOC);
    add_req(GEN_FREE_LIVE);
    add_req(GEN_SHRINK);
    drain();

    // Random phases across extreme and random settings.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin sz = 15'd8; cnt = 15'd511; end
        1: begin sz = 15'h7FFF; cnt = 15'h7FFF; end
        2: begin sz = 15'd7; cnt = 15'd1; end
        3: begin sz = 15'd64; cnt = 15'd256; end
        default: begin
          sz = 15'($urandom);
          if ($urandom_range(0, 1) == 1) sz = 15'($urandom_range(0, 4096));
          cnt = ($urandom_range(0, 3) != 0) ? 15'($urandom_range(0, 8)) : 15'($urandom);
        end
      endcase
      write_config(sz, cnt);
      if ($urandom_range(0, 1) == 1) add_req(GEN_SHRINK);
      random_phase(105);
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
